@@ rtl/rdb_pkg.sv @@
// Shared types and constants for the radix digit to binary converter.
`default_nettype none
package rdb_pkg;

  localparam int unsigned WORD_W  = 31;
  localparam int unsigned RADIX_W = 4;
  localparam int unsigned QUOT_W  = 28;
  localparam int unsigned PROD_W  = 63;

  // floor(n / 10) == (n * RECIP_TEN) >> RECIP_SHIFT for any n below 2^32
  localparam logic [31:0] RECIP_TEN   = 32'hCCCC_CCCD;
  localparam int unsigned RECIP_SHIFT = 35;

  localparam logic [RADIX_W-1:0] TOP_RADIX = 4'd9;

  // One input beat
  typedef struct packed {
    logic [WORD_W-1:0]  digit_word;
    logic [RADIX_W-1:0] radix;
  } rdb_item_t;

  // One result beat
  typedef struct packed {
    logic [WORD_W-1:0] converted;
    logic              digits_ok;
  } rdb_result_t;

  // Working state of one item as it moves down the pipe
  typedef struct packed {
    logic [WORD_W-1:0]  word;
    logic [RADIX_W-1:0] radix;
    logic               ok;
    logic [WORD_W-1:0]  acc;
    logic [WORD_W-1:0]  weight;
  } rdb_lane_t;

  // Lane plus the quotient of its word by ten
  typedef struct packed {
    rdb_lane_t         lane;
    logic [QUOT_W-1:0] quot;
  } rdb_div_t;

endpackage
`default_nettype wire

@@ rtl/radix_digits_to_binary.sv @@
// Top level of the radix digit to binary converter.
// Usage:
//   item channel: item_valid / item_stall / item carry digit_word and radix.
//   The decimal digits of digit_word are read as digits in base radix.
//   result channel: result_valid / result_stall / result carry converted
//   and digits_ok; a digit not below the radix, a radix above nine, or more
//   than MAX_DIGITS decimal digits gives digits_ok 0 and converted 0.
// Timing:
//   Each decimal digit takes two stages (divide by ten, then check and
//   accumulate), plus one output register. One item is accepted every cycle
//   while the pipe is not stalled.
// Reset: rst (synchronous) clears all valid bits; the pipe comes up empty.
//   item_stall is held high while rst is high.
// Stall: the whole pipe holds while a result waits under result_stall;
//   item_stall then rises in the same cycle, nothing is dropped or repeated.
`default_nettype none
module radix_digits_to_binary #(
  parameter int unsigned MAX_DIGITS = 10
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          item_valid,
  output logic               item_stall,
  input  rdb_pkg::rdb_item_t item,
  output logic               result_valid,
  input  wire logic          result_stall,
  output rdb_pkg::rdb_result_t result
);

  logic                  en;
  logic                  lane_valid [MAX_DIGITS+1];
  rdb_pkg::rdb_lane_t    lane       [MAX_DIGITS+1];
  logic                  div_valid  [MAX_DIGITS];
  rdb_pkg::rdb_div_t     div        [MAX_DIGITS];
  rdb_pkg::rdb_result_t  result_next;
  logic                  final_ok;

  // Pipe advances unless a held result blocks the output register
  assign en         = !result_valid || !result_stall;
  assign item_stall = !en || rst;

  // Entry lane
  assign lane_valid[0]    = item_valid;
  assign lane[0].word     = item.digit_word;
  assign lane[0].radix    = item.radix;
  assign lane[0].ok       = (item.radix <= rdb_pkg::TOP_RADIX);
  assign lane[0].acc      = '0;
  assign lane[0].weight   = rdb_pkg::WORD_W'(1);

  // One divide stage and one accumulate stage per decimal digit
  for (genvar g = 0; g < MAX_DIGITS; g++) begin : g_digit
    rdb_div_stage u_div (
      .clk        (clk),
      .rst        (rst),
      .en         (en),
      .lane_valid (lane_valid[g]),
      .lane       (lane[g]),
      .div_valid  (div_valid[g]),
      .div        (div[g])
    );

    rdb_acc_stage u_acc (
      .clk        (clk),
      .rst        (rst),
      .en         (en),
      .div_valid  (div_valid[g]),
      .div        (div[g]),
      .lane_valid (lane_valid[g+1]),
      .lane       (lane[g+1])
    );
  end

  // Digits left over after the last stage make the item invalid
  assign final_ok              = lane[MAX_DIGITS].ok && (lane[MAX_DIGITS].word == '0);
  assign result_next.digits_ok = final_ok;
  assign result_next.converted = final_ok ? lane[MAX_DIGITS].acc : '0;

  // Output register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (en) begin
      result_valid <= lane_valid[MAX_DIGITS];
    end
  end

  // Output register payload
  always_ff @(posedge clk) begin
    if (en) begin
      result <= result_next;
    end
  end

endmodule
`default_nettype wire

@@ rtl/rdb_div_stage.sv @@
// Pipeline stage that divides the remaining word by ten with a reciprocal multiply.
`default_nettype none
module rdb_div_stage (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              en,
  input  wire logic              lane_valid,
  input  rdb_pkg::rdb_lane_t     lane,
  output logic                   div_valid,
  output rdb_pkg::rdb_div_t      div
);

  logic [rdb_pkg::PROD_W-1:0] prod;

  // word * ceil(2^35 / 10); quotient sits in the top bits
  assign prod = rdb_pkg::PROD_W'(lane.word) * rdb_pkg::PROD_W'(rdb_pkg::RECIP_TEN);

  // Valid bit
  always_ff @(posedge clk) begin
    if (rst) begin
      div_valid <= 1'b0;
    end else if (en) begin
      div_valid <= lane_valid;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (en) begin
      div.lane <= lane;
      div.quot <= prod[rdb_pkg::RECIP_SHIFT +: rdb_pkg::QUOT_W];
    end
  end

endmodule
`default_nettype wire

@@ rtl/rdb_acc_stage.sv @@
// Pipeline stage that checks one decimal digit and folds it into the sum.
`default_nettype none
module rdb_acc_stage (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              en,
  input  wire logic              div_valid,
  input  rdb_pkg::rdb_div_t      div,
  output logic                   lane_valid,
  output rdb_pkg::rdb_lane_t     lane
);

  logic [rdb_pkg::WORD_W-1:0] tens;
  logic [rdb_pkg::WORD_W-1:0] rem;
  logic [3:0]                 digit;
  logic                       live;
  rdb_pkg::rdb_lane_t         lane_next;

  // Digit = word - 10 * quotient, the 10 as shift-adds
  assign tens  = rdb_pkg::WORD_W'({div.quot, 3'b000}) + rdb_pkg::WORD_W'({div.quot, 1'b0});
  assign rem   = div.lane.word - tens;
  assign digit = rem[3:0];
  assign live  = div.lane.ok && (div.lane.word != '0);

  // Check and accumulate; an exhausted word leaves the lane as it is
  always_comb begin
    lane_next      = div.lane;
    lane_next.word = rdb_pkg::WORD_W'(div.quot);
    if (live) begin
      if (digit >= div.lane.radix) begin
        lane_next.ok = 1'b0;
      end else begin
        lane_next.acc    = div.lane.acc
                         + rdb_pkg::WORD_W'(div.lane.weight * rdb_pkg::WORD_W'(digit));
        lane_next.weight = rdb_pkg::WORD_W'(div.lane.weight
                         * rdb_pkg::WORD_W'(div.lane.radix));
      end
    end
  end

  // Valid bit
  always_ff @(posedge clk) begin
    if (rst) begin
      lane_valid <= 1'b0;
    end else if (en) begin
      lane_valid <= div_valid;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (en) begin
      lane <= lane_next;
    end
  end

endmodule
`default_nettype wire

@@ dv/tb.sv @@
// Self-checking testbench for the radix digit to binary converter.
`default_nettype none
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned DIGITS_MAX     = 10;
  localparam int unsigned PIPE_LATENCY   = 2 * DIGITS_MAX + 1;
  localparam int unsigned RANDOM_ITEMS   = 1900;
  localparam int unsigned QUIET_LIMIT    = 2000;
  localparam int unsigned HOLDOFF_CYCLES = 300;
  localparam int unsigned IDLE_PCT       = 17;
  localparam longint unsigned WORD_MAX   = 64'h7FFF_FFFF;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 item_valid = 1'b0;
  logic                 item_stall;
  rdb_pkg::rdb_item_t   item = '0;
  logic                 result_valid;
  logic                 result_stall = 1'b0;
  rdb_pkg::rdb_result_t result;

  rdb_pkg::rdb_item_t   pending_items[$];
  rdb_pkg::rdb_result_t expected_results[$];
  int unsigned items_accepted = 0;
  int unsigned results_seen = 0;
  int unsigned total_items = 0;
  int unsigned errors = 0;
  int unsigned quiet_cycles = 0;
  int unsigned hold_left = 0;
  logic        hold_done = 1'b0;
  logic        item_took = 1'b0;

  radix_digits_to_binary #(.MAX_DIGITS(DIGITS_MAX)) u_dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  always #2 clk = ~clk;

  // Value of the decimal digits of a word read in the given radix
  function automatic rdb_pkg::rdb_result_t radix_value(rdb_pkg::rdb_item_t beat);
    longint unsigned      rest;
    longint unsigned      digit;
    longint unsigned      acc;
    longint unsigned      weight;
    logic                 ok;
    int unsigned          pos;
    rdb_pkg::rdb_result_t res;
    rest   = 64'(beat.digit_word);
    acc    = 0;
    weight = 1;
    ok     = (beat.radix <= rdb_pkg::TOP_RADIX);
    pos    = 0;
    while (ok && pos < DIGITS_MAX && rest != 0) begin
      digit = rest % 10;
      rest  = rest / 10;
      if (digit >= 64'(beat.radix)) begin
        ok = 1'b0;
      end else begin
        acc    = acc + digit * weight;
        weight = weight * 64'(beat.radix);
      end
      pos++;
    end
    // digits left over past the limit make the word unusable
    if (ok && rest != 0) ok = 1'b0;
    res.converted = ok ? acc[rdb_pkg::WORD_W-1:0] : '0;
    res.digits_ok = ok;
    return res;
  endfunction

  // Word whose decimal digits are all valid in the given radix
  function automatic longint unsigned legal_word(int unsigned rdx, int unsigned ndig);
    longint unsigned w;
    w = 0;
    for (int unsigned i = 0; i < ndig; i++) begin
      w = w * 10 + $urandom_range(rdx - 1, 0);
    end
    if (w > WORD_MAX) w = w % 64'd1_000_000_000;
    return w;
  endfunction

  task automatic add_item(longint unsigned w, int unsigned rdx);
    rdb_pkg::rdb_item_t beat;
    beat.digit_word = w[rdb_pkg::WORD_W-1:0];
    beat.radix      = rdx[rdb_pkg::RADIX_W-1:0];
    pending_items.push_back(beat);
  endtask

  // Input driver: holds a stalled beat, otherwise offers the next one or idles
  always @(negedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (!item_valid || item_took) begin
      if (pending_items.size() > 0 &&
          ((items_accepted >= 1000 && items_accepted < 1350) ||
           $urandom_range(99, 0) >= IDLE_PCT)) begin
        item       <= pending_items.pop_front();
        item_valid <= 1'b1;
      end else begin
        item_valid <= 1'b0;
      end
    end
  end

  // Result side: random stalls, one long hold-off, one calm stretch
  always @(negedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
    end else if (hold_left > 0) begin
      result_stall <= 1'b1;
      hold_left    <= hold_left - 1;
    end else if (!hold_done && results_seen >= 400) begin
      hold_done    <= 1'b1;
      hold_left    <= HOLDOFF_CYCLES - 1;
      result_stall <= 1'b1;
    end else begin
      result_stall <= !(results_seen >= 1000 && results_seen < 1350) &&
                      ($urandom_range(99, 0) < IDLE_PCT);
    end
  end

  // Monitor: predict on each input beat, check each result beat in order
  always @(posedge clk) begin
    rdb_pkg::rdb_result_t want;
    item_took <= item_valid && !item_stall;
    if (item_valid && !item_stall) begin
      expected_results.push_back(radix_value(item));
      items_accepted <= items_accepted + 1;
    end
    if (result_valid && !result_stall) begin
      results_seen <= results_seen + 1;
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result converted=%0d digits_ok=%0b",
                 $time, result.converted, result.digits_ok);
        errors++;
      end else begin
        want = expected_results.pop_front();
        if (result.converted !== want.converted) begin
          $display("%0t: converted mismatch: expected %0d, actual %0d",
                   $time, want.converted, result.converted);
          errors++;
        end
        if (result.digits_ok !== want.digits_ok) begin
          $display("%0t: digits_ok mismatch: expected %0b, actual %0b",
                   $time, want.digits_ok, result.digits_ok);
          errors++;
        end
      end
    end
  end

  // Watchdog on cycles with no beat moving on either side
  always @(posedge clk) begin
    if (rst || (item_valid && !item_stall) || (result_valid && !result_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: timeout, no beat for %0d cycles", $time, quiet_cycles);
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    int unsigned     rdx;
    int unsigned     pick;
    longint unsigned w;

    // zero word in every kind of radix
    add_item(0, 2);
    add_item(0, 0);
    add_item(0, 1);
    add_item(0, 9);
    add_item(0, 15);
    // largest word, valid in nine, not in eight
    add_item(WORD_MAX, 9);
    add_item(WORD_MAX, 8);
    add_item(WORD_MAX, 15);
    // ten-digit words and the top bit of the word
    add_item(1111111111, 2);
    add_item(1010101010, 2);
    add_item(1073741824, 9);
    add_item(2088888888, 9);
    add_item(2000000000, 3);
    add_item(888888888, 9);
    // radix one and zero
    add_item(1000000000, 1);
    add_item(11, 1);
    add_item(1, 1);
    add_item(5, 0);
    // small values and a digit equal to the radix
    add_item(1, 2);
    add_item(10, 2);
    add_item(9, 9);
    add_item(12, 10);
    add_item(76543210, 8);

    // random part: mostly legal digit strings, some with one bad digit, some noise
    for (int unsigned i = 0; i < RANDOM_ITEMS; i++) begin
      pick = $urandom_range(99, 0);
      rdx  = $urandom_range(9, 2);
      if (pick < 65) begin
        add_item(legal_word(rdx, $urandom_range(10, 1)), rdx);
      end else if (pick < 80) begin
        w = legal_word(rdx, $urandom_range(9, 0)) * 10 + $urandom_range(9, rdx);
        if (w > WORD_MAX) w = w % 64'd1_000_000_000;
        add_item(w, rdx);
      end else begin
        add_item({1'b0, $urandom()} & WORD_MAX, $urandom_range(15, 0));
      end
    end
    total_items = pending_items.size();

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (items_accepted < total_items || expected_results.size() > 0) begin
      @(negedge clk);
    end
    repeat (PIPE_LATENCY + 4) @(negedge clk);

    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
`default_nettype wire

@@ files.f @@
rtl/rdb_pkg.sv
rtl/rdb_div_stage.sv
rtl/rdb_acc_stage.sv
rtl/radix_digits_to_binary.sv
dv/tb.sv
